/* rtl/csb_pkg.sv */
// ----------------------------------------------------------------------------
// csb_pkg: shared types and helpers for the clipped sprite blitter
// Request codes, controller/datapath interface structs, lane helpers.
// ----------------------------------------------------------------------------
package csb_pkg;

  localparam int MAX_SCREEN_DIM = 4096;
  localparam int MAX_SPRITE_DIM = 4095;

  localparam logic [1:0] ACT_PLOT  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_PIXEL = 2'd2;

  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BYTES_PER_PIX = 2'd2;

  localparam logic [12:0] RESET_WIDTH  = 13'd1024;
  localparam logic [12:0] RESET_HEIGHT = 13'd768;
  localparam logic [2:0]  RESET_BPP    = 3'd4;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic clip;     // resolve coordinates, clip, update sprite walk
    logic mul;      // row stride multiply
    logic load;     // load the output register
  } csb_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic emit;      // request produces a write
    logic out_free;  // output register can take a new write
  } csb_status_t;

  // Colour bits kept for a given pixel size
  function automatic logic [31:0] lane_mask(input logic [2:0] bpp);
    logic [31:0] m;
    unique case (bpp)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [3:0] lane_enable(input logic [2:0] bpp);
    logic [3:0] e;
    unique case (bpp)
      3'd1:    e = 4'b0001;
      3'd2:    e = 4'b0011;
      3'd3:    e = 4'b0111;
      3'd4:    e = 4'b1111;
      default: e = 4'b0000;
    endcase
    return e;
  endfunction

  // Clamp a 13-bit screen dimension to the supported maximum
  function automatic logic [12:0] clamp_screen(input logic [12:0] v);
    logic [12:0] lim;
    lim = 13'(MAX_SCREEN_DIM);
    return (v > lim) ? lim : v;
  endfunction

endpackage

/* rtl/csb_ctrl.sv */
// ----------------------------------------------------------------------------
// csb_ctrl: request sequencer
// Steps each request through clip, stride multiply and address stages.
// ----------------------------------------------------------------------------
module csb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  csb_pkg::csb_status_t status,
  output csb_pkg::csb_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CLIP = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_ADDR = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_next = ST_CLIP;
      end
      ST_CLIP: begin
        cmd.clip   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        // hold here while the previous write still waits
        if (!status.emit) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == ST_ADDR) && status.emit && status.out_free)
    else $error("output load without a free output register");

  a_request_spacing: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("request accepted before the previous one finished");

endmodule

/* rtl/csb_datapath.sv */
// ----------------------------------------------------------------------------
// csb_datapath: blitter datapath
// Configuration, sprite walk state, clipping, address arithmetic, output reg.
// ----------------------------------------------------------------------------
module csb_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [12:0]          cfg_data,
  input  logic [1:0]           action,
  input  logic [15:0]          pos_x,
  input  logic [15:0]          pos_y,
  input  logic [11:0]          sprite_w,
  input  logic [11:0]          sprite_h,
  input  logic                 rotate,
  input  logic [31:0]          color,
  input  csb_pkg::csb_cmd_t    cmd,
  output csb_pkg::csb_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [25:0]          write_address,
  output logic [31:0]          write_data,
  output logic [3:0]           byte_enable
);

  // configuration
  logic [12:0] screen_width;
  logic [12:0] screen_height;
  logic [2:0]  bytes_per_pixel;

  // sprite walk
  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [11:0] sprite_width;
  logic [11:0] sprite_height;
  logic        rotated;
  logic [11:0] source_row;
  logic [11:0] source_col;

  // captured request
  logic [1:0]  req_action;
  logic [15:0] req_x;
  logic [15:0] req_y;
  logic [11:0] req_w;
  logic [11:0] req_h;
  logic        req_rot;
  logic [31:0] req_color;

  // stage registers
  logic [11:0] pix_x;
  logic [11:0] pix_y;
  logic        emit;
  logic [31:0] pix_data;
  logic [24:0] row_base;

  // combinational
  logic [12:0] width_clamped;
  logic [12:0] height_clamped;
  logic        exhausted;
  logic [11:0] rot_offset;
  logic [15:0] dst_x;
  logic [15:0] dst_y;
  logic [31:0] masked_color;
  logic        bpp_ok;
  logic        on_screen;
  logic        emit_next;
  logic [11:0] col_inc;
  logic [24:0] linear;
  logic [27:0] byte_addr;

  assign width_clamped  = csb_pkg::clamp_screen(screen_width);
  assign height_clamped = csb_pkg::clamp_screen(screen_height);

  assign exhausted  = (sprite_width == 12'd0) || (sprite_height == 12'd0) ||
                      (source_row >= sprite_height);
  assign rot_offset = sprite_height - 12'd1 - source_row;
  assign col_inc    = source_col + 12'd1;

  always_comb begin
    if (req_action == csb_pkg::ACT_PLOT) begin
      dst_x = req_x;
      dst_y = req_y;
    end else if (rotated) begin
      dst_x = origin_x + {4'd0, rot_offset};
      dst_y = origin_y + {4'd0, source_col};
    end else begin
      dst_x = origin_x + {4'd0, source_col};
      dst_y = origin_y + {4'd0, source_row};
    end
  end

  assign masked_color = req_color & csb_pkg::lane_mask(bytes_per_pixel);
  assign bpp_ok       = (bytes_per_pixel != 3'd0) && (bytes_per_pixel <= 3'd4);
  assign on_screen    = (dst_x < {3'd0, width_clamped}) && (dst_y < {3'd0, height_clamped});

  always_comb begin
    priority if (req_action == csb_pkg::ACT_PLOT) begin
      emit_next = bpp_ok && on_screen;
    end else if (req_action == csb_pkg::ACT_PIXEL) begin
      // a transparent pixel still advances the walk
      emit_next = !exhausted && (masked_color != 32'd0) && bpp_ok && on_screen;
    end else begin
      emit_next = 1'b0;
    end
  end

  assign linear    = row_base + {13'd0, pix_x};
  assign byte_addr = {3'd0, linear} * {25'd0, bytes_per_pixel};

  assign status.emit     = emit;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width    <= csb_pkg::RESET_WIDTH;
      screen_height   <= csb_pkg::RESET_HEIGHT;
      bytes_per_pixel <= csb_pkg::RESET_BPP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csb_pkg::REG_SCREEN_WIDTH:  screen_width    <= cfg_data;
        csb_pkg::REG_SCREEN_HEIGHT: screen_height   <= cfg_data;
        csb_pkg::REG_BYTES_PER_PIX: bytes_per_pixel <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      sprite_width  <= '0;
      sprite_height <= '0;
      rotated       <= 1'b0;
      source_row    <= '0;
      source_col    <= '0;
    end else if (cmd.clip) begin
      if (req_action == csb_pkg::ACT_START) begin
        // 12-bit sizes never exceed the sprite limit, so no clamp is needed
        origin_x      <= req_x;
        origin_y      <= req_y;
        sprite_width  <= req_w;
        sprite_height <= req_h;
        rotated       <= req_rot;
        source_row    <= '0;
        source_col    <= '0;
      end else if ((req_action == csb_pkg::ACT_PIXEL) && !exhausted) begin
        if (col_inc >= sprite_width) begin
          source_col <= '0;
          source_row <= source_row + 12'd1;
        end else begin
          source_col <= col_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_action <= action;
      req_x      <= pos_x;
      req_y      <= pos_y;
      req_w      <= sprite_w;
      req_h      <= sprite_h;
      req_rot    <= rotate;
      req_color  <= color;
    end
    if (cmd.clip) begin
      pix_x    <= dst_x[11:0];
      pix_y    <= dst_y[11:0];
      pix_data <= masked_color;
    end
    if (cmd.mul) begin
      row_base <= {13'd0, pix_y} * {12'd0, width_clamped};
    end
    if (cmd.load) begin
      write_address <= byte_addr[25:0];
      write_data    <= pix_data;
      byte_enable   <= csb_pkg::lane_enable(bytes_per_pixel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clip) emit <= emit_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_enable_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_enable != 4'd0))
    else $error("write presented with no byte lanes enabled");

  a_word_aligned: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (bytes_per_pixel == 3'd4)) |-> (write_address[1:0] == 2'd0))
    else $error("four-byte pixel write not word aligned");

endmodule

/* rtl/clipped_sprite_blitter_unit.sv */
// ----------------------------------------------------------------------------
// clipped_sprite_blitter_unit: plot and sprite blit engine with clipping
// Sequence: an accepted request is captured, clipped and stride multiplied, and
//   a write that it produces is loaded into the output register, later while an
//   earlier write is still held there. No new request is taken until the
//   sequencer has stepped capture, clip, stride multiply and address stages.
// Reset: 1024 x 768 at 4 bytes per pixel, sprite state cleared, no write pending.
// ----------------------------------------------------------------------------
module clipped_sprite_blitter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [11:0] sprite_w,
  input  logic [11:0] sprite_h,
  input  logic        rotate,
  input  logic [31:0] color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [25:0] write_address,
  output logic [31:0] write_data,
  output logic [3:0]  byte_enable
);

  csb_pkg::csb_cmd_t    cmd;
  csb_pkg::csb_status_t status;

  csb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  csb_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .sprite_w      (sprite_w),
    .sprite_h      (sprite_h),
    .rotate        (rotate),
    .color         (color),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_address (write_address),
    .write_data    (write_data),
    .byte_enable   (byte_enable)
  );

endmodule
